@@ rtl/imcol_pkg.sv @@
// Shared types, register indices and sizes for the im2col window unroller.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package imcol_pkg;

    localparam int IMAGE_WORDS = 4096;
    localparam int ADDR_W      = $clog2(IMAGE_WORDS);
    localparam int PTR_W       = $clog2(IMAGE_WORDS + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAC_A_W = 16;
    localparam int MAC_B_W = 8;
    localparam int MAC_P_W = MAC_A_W + MAC_B_W + 1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LAYOUT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PAD      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DILATION = 3'd7;

    typedef struct packed {
        logic       interleaved;
        logic [7:0] chans;
        logic [7:0] rows;
        logic [7:0] cols;
        logic [3:0] ker_h;
        logic [3:0] ker_w;
        logic [3:0] str_h;
        logic [3:0] str_w;
        logic [3:0] dil_h;
        logic [3:0] dil_w;
        logic [3:0] pad_t;
        logic [3:0] pad_l;
        logic [3:0] pad_b;
        logic [3:0] pad_r;
    } geom_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic push;
        logic last;
        logic use_word;
    } result_t;

endpackage

@@ rtl/imcol_mac.sv @@
// Shared multiply-add unit with registered product, used by the sequencer for every
// product in the window geometry and address calculation. Depends on imcol_pkg.
module imcol_mac
(
    input  logic                              clk,
    input  logic [imcol_pkg::MAC_A_W-1:0]     op_a,
    input  logic [imcol_pkg::MAC_B_W-1:0]     op_b,
    input  logic [imcol_pkg::MAC_A_W-1:0]     op_c,
    output logic [imcol_pkg::MAC_P_W-1:0]     product_reg
);

    logic [imcol_pkg::MAC_P_W-1:0] product_next;

    assign product_next = imcol_pkg::MAC_P_W'(op_a * op_b)
                        + imcol_pkg::MAC_P_W'(op_c);

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

endmodule

@@ rtl/imcol_store.sv @@
// Image word store with its load pointer; one write and one registered read port.
// Depends on imcol_pkg.
module imcol_store
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [31:0]                    wr_data,
    input  logic                           wr_last,
    input  imcol_pkg::rd_req_t             rd_req,
    output logic [31:0]                    rd_data_reg,
    output logic [imcol_pkg::PTR_W-1:0]    load_ptr
);

    logic [31:0]                 mem [imcol_pkg::IMAGE_WORDS];
    logic [imcol_pkg::PTR_W-1:0] ptr_reg;
    logic [imcol_pkg::PTR_W-1:0] ptr_next;
    logic                        room;

    assign room     = ptr_reg < imcol_pkg::PTR_W'(imcol_pkg::IMAGE_WORDS);
    assign load_ptr = ptr_reg;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (wr_en)
        begin
            if (room)
            begin
                ptr_next = ptr_reg + imcol_pkg::PTR_W'(1);
            end
            if (wr_last)
            begin
                ptr_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && room)
        begin
            mem[ptr_reg[imcol_pkg::ADDR_W-1:0]] <= wr_data;
        end
        if (rd_req.en)
        begin
            rd_data_reg <= mem[rd_req.addr];
        end
    end

endmodule

@@ rtl/imcol_seq.sv @@
// Per-pull sequencer: drives the shared multiply-add through the window geometry,
// keeps the traversal counters and issues the store read. Depends on imcol_pkg.
module imcol_seq
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  imcol_pkg::geom_t                  geom,
    input  logic                              start,
    input  logic                              cfg_clear,
    input  logic                              out_free,
    input  logic [imcol_pkg::MAC_P_W-1:0]     product,
    output logic [imcol_pkg::MAC_A_W-1:0]     op_a,
    output logic [imcol_pkg::MAC_B_W-1:0]     op_b,
    output logic [imcol_pkg::MAC_A_W-1:0]     op_c,
    output logic                              busy,
    output imcol_pkg::rd_req_t                rd_req,
    output imcol_pkg::result_t                res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SPAN_H = 4'd1;
    localparam logic [3:0] S_SPAN_W = 4'd2;
    localparam logic [3:0] S_ROW0   = 4'd3;
    localparam logic [3:0] S_ROW1   = 4'd4;
    localparam logic [3:0] S_COL0   = 4'd5;
    localparam logic [3:0] S_COL1   = 4'd6;
    localparam logic [3:0] S_NXT_R  = 4'd7;
    localparam logic [3:0] S_NXT_C  = 4'd8;
    localparam logic [3:0] S_ADR0   = 4'd9;
    localparam logic [3:0] S_ADR1   = 4'd10;
    localparam logic [3:0] S_READ   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]         state_reg, state_next;
    logic [7:0]         ch_reg, ch_next;
    logic [3:0]         kr_reg, kr_next;
    logic [3:0]         kc_reg, kc_next;
    logic [7:0]         or_reg, or_next;
    logic [7:0]         oc_reg, oc_next;

    logic [7:0]         span_h_reg;
    logic [7:0]         span_w_reg;
    logic signed [13:0] row_reg;
    logic signed [13:0] col_reg;
    logic               can_r_reg;
    logic               can_c_reg;
    logic               inside_reg;
    logic               use_reg;
    logic               last_reg;

    logic [9:0]         padded_h, padded_w;
    logic signed [10:0] room_h, room_w;
    logic signed [13:0] pos_next;
    logic               ok_ch, ok_kr, ok_kc;
    logic               wrap;
    logic               empty;

    assign padded_h = {2'b0, geom.rows} + {6'b0, geom.pad_t}
                    + {6'b0, (geom.interleaved ? geom.pad_b : geom.pad_t)};
    assign padded_w = {2'b0, geom.cols} + {6'b0, geom.pad_l}
                    + {6'b0, (geom.interleaved ? geom.pad_r : geom.pad_l)};
    assign room_h   = $signed({1'b0, padded_h}) - $signed({3'b0, span_h_reg});
    assign room_w   = $signed({1'b0, padded_w}) - $signed({3'b0, span_w_reg});

    assign pos_next = $signed({1'b0, product[12:0]})
                    - $signed({10'b0, (state_reg == S_COL0) ? geom.pad_t : geom.pad_l});

    assign empty = (geom.chans == 8'd0) || (geom.rows == 8'd0) || (geom.cols == 8'd0)
                 || room_h[10] || room_w[10];

    assign ok_ch = ({1'b0, ch_reg} + 9'd1) < {1'b0, geom.chans};
    assign ok_kr = ({1'b0, kr_reg} + 5'd1) < {1'b0, geom.ker_h};
    assign ok_kc = ({1'b0, kc_reg} + 5'd1) < {1'b0, geom.ker_w};

    assign busy = state_reg != S_IDLE;

    // operand selection for the shared multiply-add
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        op_c = '0;
        unique case (state_reg)
            S_SPAN_H:
            begin
                op_a = {12'b0, geom.ker_h - 4'd1};
                op_b = {4'b0, geom.dil_h};
                op_c = 16'd1;
            end
            S_SPAN_W:
            begin
                op_a = {12'b0, geom.ker_w - 4'd1};
                op_b = {4'b0, geom.dil_w};
                op_c = 16'd1;
            end
            S_ROW0:
            begin
                op_a = {8'b0, or_reg};
                op_b = {4'b0, geom.str_h};
            end
            S_ROW1:
            begin
                op_a = {12'b0, kr_reg};
                op_b = {4'b0, geom.dil_h};
                op_c = product[15:0];
            end
            S_COL0:
            begin
                op_a = {8'b0, oc_reg};
                op_b = {4'b0, geom.str_w};
            end
            S_COL1:
            begin
                op_a = {12'b0, kc_reg};
                op_b = {4'b0, geom.dil_w};
                op_c = product[15:0];
            end
            S_NXT_R:
            begin
                op_a = {7'b0, {1'b0, or_reg} + 9'd1};
                op_b = {4'b0, geom.str_h};
            end
            S_NXT_C:
            begin
                op_a = {7'b0, {1'b0, oc_reg} + 9'd1};
                op_b = {4'b0, geom.str_w};
            end
            S_ADR0:
            begin
                if (geom.interleaved)
                begin
                    op_a = {3'b0, row_reg[12:0]};
                    op_b = geom.cols;
                    op_c = {3'b0, col_reg[12:0]};
                end
                else
                begin
                    op_a = {8'b0, ch_reg};
                    op_b = geom.rows;
                    op_c = {3'b0, row_reg[12:0]};
                end
            end
            S_ADR1:
            begin
                op_a = product[15:0];
                if (geom.interleaved)
                begin
                    op_b = geom.chans;
                    op_c = {8'b0, ch_reg};
                end
                else
                begin
                    op_b = geom.cols;
                    op_c = {3'b0, col_reg[12:0]};
                end
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // odometer advance; innermost counter first
    always_comb
    begin
        ch_next = ch_reg;
        kr_next = kr_reg;
        kc_next = kc_reg;
        or_next = or_reg;
        oc_next = oc_reg;
        wrap    = 1'b0;
        if (geom.interleaved)
        begin
            if (ok_ch) ch_next = ch_reg + 8'd1;
            else
            begin
                ch_next = '0;
                if (ok_kc) kc_next = kc_reg + 4'd1;
                else
                begin
                    kc_next = '0;
                    if (ok_kr) kr_next = kr_reg + 4'd1;
                    else
                    begin
                        kr_next = '0;
                        if (can_c_reg) oc_next = oc_reg + 8'd1;
                        else
                        begin
                            oc_next = '0;
                            if (can_r_reg) or_next = or_reg + 8'd1;
                            else
                            begin
                                or_next = '0;
                                wrap    = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        else
        begin
            if (can_c_reg) oc_next = oc_reg + 8'd1;
            else
            begin
                oc_next = '0;
                if (can_r_reg) or_next = or_reg + 8'd1;
                else
                begin
                    or_next = '0;
                    if (ok_kc) kc_next = kc_reg + 4'd1;
                    else
                    begin
                        kc_next = '0;
                        if (ok_kr) kr_next = kr_reg + 4'd1;
                        else
                        begin
                            kr_next = '0;
                            if (ok_ch) ch_next = ch_reg + 8'd1;
                            else
                            begin
                                ch_next = '0;
                                wrap    = 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   state_next = start ? S_SPAN_H : S_IDLE;
            S_SPAN_H: state_next = S_SPAN_W;
            S_SPAN_W: state_next = S_ROW0;
            S_ROW0:   state_next = S_ROW1;
            S_ROW1:   state_next = S_COL0;
            S_COL0:   state_next = S_COL1;
            S_COL1:   state_next = S_NXT_R;
            S_NXT_R:  state_next = S_NXT_C;
            S_NXT_C:  state_next = S_ADR0;
            S_ADR0:   state_next = empty ? S_IDLE : S_ADR1;
            S_ADR1:   state_next = S_READ;
            S_READ:   state_next = S_DONE;
            S_DONE:   state_next = out_free ? S_IDLE : S_DONE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign rd_req.en   = state_reg == S_READ;
    assign rd_req.addr = product[imcol_pkg::ADDR_W-1:0];

    assign res.push     = (state_reg == S_DONE) && out_free;
    assign res.last     = last_reg;
    assign res.use_word = use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
            kr_reg    <= '0;
            kc_reg    <= '0;
            or_reg    <= '0;
            oc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_clear)
            begin
                ch_reg <= '0;
                kr_reg <= '0;
                kc_reg <= '0;
                or_reg <= '0;
                oc_reg <= '0;
            end
            else if (state_reg == S_READ)
            begin
                ch_reg <= ch_next;
                kr_reg <= kr_next;
                kc_reg <= kc_next;
                or_reg <= or_next;
                oc_reg <= oc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_SPAN_W: span_h_reg <= product[7:0];
            S_ROW0:   span_w_reg <= product[7:0];
            S_COL0:   row_reg    <= pos_next;
            S_NXT_R:  col_reg    <= pos_next;
            S_NXT_C:
            begin
                can_r_reg <= (or_reg != 8'hFF) && !room_h[10]
                           && (product[12:0] <= {3'b0, room_h[9:0]});
            end
            S_ADR0:
            begin
                can_c_reg  <= (oc_reg != 8'hFF) && !room_w[10]
                            && (product[12:0] <= {3'b0, room_w[9:0]});
                inside_reg <= !row_reg[13] && (row_reg[12:0] < {5'b0, geom.rows})
                           && !col_reg[13] && (col_reg[12:0] < {5'b0, geom.cols});
            end
            S_READ:
            begin
                use_reg  <= inside_reg
                         && (product < imcol_pkg::MAC_P_W'(imcol_pkg::IMAGE_WORDS));
                last_reg <= wrap;
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

endmodule

@@ rtl/im2col_window_unroller.sv @@
// im2col window unroller top level: configuration registers, result register,
// store and sequencer. Depends on imcol_pkg, imcol_mac, imcol_store, imcol_seq.
// The store accepts one load word per cycle while no pull is in progress (in_stall).
// A pull passes ten products through the one shared multiply-add unit in the
// sequencer, then reads its word from the store into the result register.
// Reset clears the registers to their defaults, the load pointer and the counters.
module im2col_window_unroller
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               kind,
    input  logic [31:0]                        pixel_data,
    input  logic                               load_last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [31:0]                        column_value,
    output logic                               column_last,
    input  logic                               cfg_we,
    input  logic [imcol_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [imcol_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic        layout_reg;
    logic [7:0]  channels_reg;
    logic [7:0]  height_reg;
    logic [7:0]  width_reg;
    logic [7:0]  kernel_reg;
    logic [15:0] pad_reg;
    logic [7:0]  stride_reg;
    logic [7:0]  dilation_reg;

    logic        out_valid_reg;
    logic [31:0] column_value_reg;
    logic        column_last_reg;

    imcol_pkg::geom_t                geom;
    imcol_pkg::rd_req_t              rd_req;
    imcol_pkg::result_t              res;
    logic [31:0]                     rd_data;
    logic [imcol_pkg::PTR_W-1:0]     load_ptr;
    logic [imcol_pkg::MAC_A_W-1:0]   op_a, op_c;
    logic [imcol_pkg::MAC_B_W-1:0]   op_b;
    logic [imcol_pkg::MAC_P_W-1:0]   product;
    logic                            busy;
    logic                            in_xfer;
    logic                            load_xfer;
    logic                            pull_xfer;
    logic                            out_free;

    function automatic logic [3:0] nib_one(input logic [3:0] n);
        nib_one = (n == 4'd0) ? 4'd1 : n;
    endfunction

    assign in_stall  = busy;
    assign in_xfer   = in_valid && !in_stall;
    assign load_xfer = in_xfer && (kind == imcol_pkg::KIND_LOAD);
    assign pull_xfer = in_xfer && (kind == imcol_pkg::KIND_PULL);
    assign out_free  = !out_valid_reg || !out_stall;

    assign geom.interleaved = layout_reg;
    assign geom.chans       = channels_reg;
    assign geom.rows        = height_reg;
    assign geom.cols        = width_reg;
    assign geom.ker_h       = nib_one(kernel_reg[7:4]);
    assign geom.ker_w       = nib_one(kernel_reg[3:0]);
    assign geom.str_h       = nib_one(stride_reg[7:4]);
    assign geom.str_w       = nib_one(stride_reg[3:0]);
    assign geom.dil_h       = nib_one(dilation_reg[7:4]);
    assign geom.dil_w       = nib_one(dilation_reg[3:0]);
    assign geom.pad_t       = pad_reg[15:12];
    assign geom.pad_l       = pad_reg[11:8];
    assign geom.pad_b       = pad_reg[7:4];
    assign geom.pad_r       = pad_reg[3:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg   <= 1'b0;
            channels_reg <= 8'd1;
            height_reg   <= 8'd8;
            width_reg    <= 8'd8;
            kernel_reg   <= 8'h33;
            pad_reg      <= 16'h0000;
            stride_reg   <= 8'h11;
            dilation_reg <= 8'h11;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                imcol_pkg::REG_LAYOUT:   layout_reg   <= cfg_data[0];
                imcol_pkg::REG_CHANNELS: channels_reg <= cfg_data[7:0];
                imcol_pkg::REG_HEIGHT:   height_reg   <= cfg_data[7:0];
                imcol_pkg::REG_WIDTH:    width_reg    <= cfg_data[7:0];
                imcol_pkg::REG_KERNEL:   kernel_reg   <= cfg_data[7:0];
                imcol_pkg::REG_PAD:      pad_reg      <= cfg_data;
                imcol_pkg::REG_STRIDE:   stride_reg   <= cfg_data[7:0];
                imcol_pkg::REG_DILATION: dilation_reg <= cfg_data[7:0];
                default:                 layout_reg   <= layout_reg;
            endcase
        end
    end

    imcol_mac u_mac
    (
        .clk         (clk),
        .op_a        (op_a),
        .op_b        (op_b),
        .op_c        (op_c),
        .product_reg (product)
    );

    imcol_store u_store
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (load_xfer),
        .wr_data     (pixel_data),
        .wr_last     (load_last),
        .rd_req      (rd_req),
        .rd_data_reg (rd_data),
        .load_ptr    (load_ptr)
    );

    imcol_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .start     (pull_xfer),
        .cfg_clear (cfg_we),
        .out_free  (out_free),
        .product   (product),
        .op_a      (op_a),
        .op_b      (op_b),
        .op_c      (op_c),
        .busy      (busy),
        .rd_req    (rd_req),
        .res       (res)
    );

    // result register: holds a finished word until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            column_value_reg <= res.use_word ? rd_data : 32'd0;
            column_last_reg  <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign column_value = column_value_reg;
    assign column_last  = column_last_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |-> !(out_valid_reg && out_stall))
        else $error("result written over a waiting transfer");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_ptr <= imcol_pkg::PTR_W'(imcol_pkg::IMAGE_WORDS))
        else $error("load pointer beyond store");

    a_pull_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pull_xfer |=> in_stall)
        else $error("pull transfer did not start the sequencer");

endmodule
